// ----- rtl/core/fixed_block_free_list_allocator_assert.svh -----
// Assertion macros shared by the allocator modules.
// Each macro takes a label, the clock, the active-low reset and the checked terms.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Condition holds at every clock edge outside reset.
`define FBFLA_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("allocator invariant violated");
// Consequent holds in the same cycle as the antecedent.
`define FBFLA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("allocator implication violated");
// Consequent holds in the cycle after the antecedent.
`define FBFLA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("allocator sequence violated");
`else
`define FBFLA_ASSERT_ALWAYS(label, clk, rstn, cond)
`define FBFLA_ASSERT_IMP(label, clk, rstn, ante, cons)
`define FBFLA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/core/fbfla_pkg.sv -----
package fbfla_pkg;

    // Pool geometry. Block indexes are eight bits wide on the ports.
    localparam int MAX_BLOCKS = 256;
    localparam int ADDR_W     = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = ADDR_W + 1;
    localparam logic [LINK_W-1:0] LIST_END = LINK_W'(MAX_BLOCKS);

    localparam int BYTES_W  = 13;
    localparam int COUNT_W  = 9;
    localparam int CFG_W    = 13;
    localparam int OFFSET_W = 20;
    localparam int TDATA_W  = 32;

    localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(16);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);

    // Request kinds.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Configuration register indexes.
    localparam logic REG_BLOCK_BYTES = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic out_from_exec;
        logic out_from_pend;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/core/fbfla_ram.sv -----
module fbfla_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/fbfla_ctrl.sv -----
`include "fixed_block_free_list_allocator_assert.svh"

module fbfla_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output fbfla_pkg::cmd_t cmd,
    input  fbfla_pkg::sts_t sts
);

    import fbfla_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = sts.out_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // No request is taken while reset is held.
    always_comb begin
        s_tready          = 1'b0;
        cmd               = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = aresetn;
                cmd.accept = s_tvalid && aresetn;
            end
            ST_EXEC: begin
                cmd.exec          = 1'b1;
                cmd.out_from_exec = sts.out_free;
            end
            ST_HOLD: begin
                cmd.out_from_pend = sts.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // A taken request is executed in the very next cycle, and only once.
    `FBFLA_ASSERT_NEXT(a_accept_then_exec, aclk, aresetn, cmd.accept, state_reg == ST_EXEC)
    `FBFLA_ASSERT_NEXT(a_exec_once, aclk, aresetn, state_reg == ST_EXEC, state_reg != ST_EXEC)
    // The input is only open while no request is in flight.
    `FBFLA_ASSERT_IMP(a_ready_when_idle, aclk, aresetn, s_tready, state_reg == ST_IDLE)

endmodule

// ----- rtl/core/fbfla_dp.sv -----
`include "fixed_block_free_list_allocator_assert.svh"

module fbfla_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [fbfla_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [fbfla_pkg::ADDR_W-1:0]        s_tdata,
    input  logic                                s_tuser,
    input  fbfla_pkg::cmd_t                     cmd,
    output fbfla_pkg::sts_t                     sts,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [fbfla_pkg::TDATA_W-1:0]       m_tdata,
    output logic [1:0]                          m_tuser
);

    import fbfla_pkg::*;

    // Configuration and list head.
    logic [BYTES_W-1:0]    bytes_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [LINK_W-1:0]     head_reg;
    logic [LINK_W-1:0]     head_next;
    logic [MAX_BLOCKS-1:0] valid_reg;

    // Latched request.
    logic              mode_reg;
    logic [ADDR_W-1:0] idx_reg;

    // Result waiting for the output register.
    status_t             pend_status_reg;
    logic [ADDR_W-1:0]   pend_index_reg;
    logic [OFFSET_W-1:0] pend_offset_reg;

    // Output register.
    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [ADDR_W-1:0]   m_index_reg;
    logic [OFFSET_W-1:0] m_offset_reg;

    logic [COUNT_W-1:0]  pool_n;
    logic [COUNT_W-1:0]  cfg_count;
    logic [COUNT_W-1:0]  cfg_n;
    logic [LINK_W-1:0]   head_inc;
    logic [LINK_W-1:0]   dflt_link;
    logic [LINK_W-1:0]   ram_rdata;
    logic [LINK_W-1:0]   link_val;
    logic [BYTES_W+ADDR_W-1:0] prod;
    logic                ram_we;
    logic                set_valid;

    status_t             res_status;
    logic [ADDR_W-1:0]   res_index;
    logic [OFFSET_W-1:0] res_offset;

    // Block count saturates at the pool capacity.
    assign pool_n    = (count_reg > COUNT_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS) : count_reg;
    assign cfg_count = (cfg_wdata[COUNT_W-1:0] > COUNT_W'(MAX_BLOCKS)) ?
                       COUNT_W'(MAX_BLOCKS) : cfg_wdata[COUNT_W-1:0];
    assign cfg_n     = (cfg_index == REG_BLOCK_COUNT) ? cfg_count : pool_n;

    // A link never written since the last rebuild reads as the in-order chain.
    assign head_inc  = head_reg + LINK_W'(1);
    assign dflt_link = (head_inc < LINK_W'(pool_n)) ? head_inc : LIST_END;
    assign link_val  = valid_reg[head_reg[ADDR_W-1:0]] ? ram_rdata : dflt_link;

    assign prod = (BYTES_W+ADDR_W)'(head_reg[ADDR_W-1:0]) * (BYTES_W+ADDR_W)'(bytes_reg);

    always_comb begin
        head_next  = head_reg;
        ram_we     = 1'b0;
        set_valid  = 1'b0;
        res_status = STATUS_DONE;
        res_index  = '0;
        res_offset = '0;
        if (mode_reg == MODE_ALLOC) begin
            if (head_reg == LIST_END) begin
                res_status = STATUS_EMPTY;
            end else begin
                res_index  = head_reg[ADDR_W-1:0];
                res_offset = prod[OFFSET_W-1:0];
                head_next  = link_val;
            end
        end else begin
            if (COUNT_W'(idx_reg) >= pool_n) begin
                res_status = STATUS_RANGE;
            end else begin
                ram_we    = cmd.exec;
                set_valid = cmd.exec;
                head_next = LINK_W'(idx_reg);
            end
        end
    end

    fbfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (head_reg),
        .raddr (head_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_reg   <= BYTES_RESET;
            count_reg   <= COUNT_RESET;
            head_reg    <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_BLOCK_BYTES) begin
                    bytes_reg <= cfg_wdata[BYTES_W-1:0];
                end else begin
                    count_reg <= cfg_wdata[COUNT_W-1:0];
                end
                valid_reg <= '0;
                head_reg  <= (cfg_n != '0) ? '0 : LIST_END;
            end else if (cmd.exec) begin
                head_reg <= head_next;
                if (set_valid) begin
                    valid_reg[idx_reg] <= 1'b1;
                end
            end
            if (cmd.out_from_exec || cmd.out_from_pend) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg <= s_tuser;
            idx_reg  <= s_tdata;
        end
        if (cmd.exec && !cmd.out_from_exec) begin
            pend_status_reg <= res_status;
            pend_index_reg  <= res_index;
            pend_offset_reg <= res_offset;
        end
        if (cmd.out_from_exec) begin
            m_status_reg <= res_status;
            m_index_reg  <= res_index;
            m_offset_reg <= res_offset;
        end else if (cmd.out_from_pend) begin
            m_status_reg <= pend_status_reg;
            m_index_reg  <= pend_index_reg;
            m_offset_reg <= pend_offset_reg;
        end
    end

    assign sts.out_free = !m_valid_reg || m_tready;
    assign m_tvalid     = m_valid_reg;
    assign m_tuser      = m_status_reg;
    assign m_tdata      = {(TDATA_W-OFFSET_W-ADDR_W)'(0), m_offset_reg, m_index_reg};

    // The head is either the end marker or a block inside the configured pool.
    `FBFLA_ASSERT_ALWAYS(a_head_in_pool, aclk, aresetn,
                         head_reg == LIST_END || COUNT_W'(head_reg) < pool_n)
    // A result that grants nothing carries zero index and offset.
    `FBFLA_ASSERT_IMP(a_no_grant_zero, aclk, aresetn,
                      m_valid_reg && m_status_reg != STATUS_DONE,
                      m_index_reg == '0 && m_offset_reg == '0)
    // A stalled response stays valid and unchanged.
    `FBFLA_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid_reg && !m_tready,
                       m_valid_reg && $stable(m_tdata) && $stable(m_tuser))

endmodule

// ----- rtl/core/fixed_block_free_list_allocator.sv -----
// Fixed-size block pool allocator with a last-in-first-out free list.
// Requests arrive on the s_ channel: s_tuser selects allocate (0) or free (1),
// and s_tdata carries the block index to free. Every request yields exactly one
// response on the m_ channel: m_tuser holds the status (done, pool empty, index
// out of range), and m_tdata holds the granted index and its byte offset.
// The block size and block count are set through the cfg_ write port; the user must
// write it only while the block is idle, as the block does not enforce this. Each
// write rebuilds the free list as blocks 0 to count-1 in order. One request is in
// flight at a time: it is executed in the cycle after it is taken, and no new
// request is taken before the last one has executed. The execute step relies on the
// registered read of the link memory, which must fetch the successor of the head.
// The output register holds a finished response while the next request is taken;
// if the receiver stalls longer, that request's result waits in a holding register
// and no further request is taken until the output register drains.
// While aresetn is held low, s_tready stays low and no response is offered.
// After reset the block size is 16 bytes, the pool holds 256 blocks, and the list
// is ready at once: per-entry valid bits stand in for the reset state of the links.
module fixed_block_free_list_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [fbfla_pkg::CFG_W-1:0]   cfg_wdata,
    // Request channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] block_index
    input  logic                          s_tuser,   // [0] mode
    // Response channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fbfla_pkg::TDATA_W-1:0] m_tdata,   // [7:0] granted_index, [27:8] granted_offset
    output logic [1:0]                    m_tuser    // [1:0] status
);

    import fbfla_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The controller sequences take, execute and hand-off of each request.
    fbfla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // The datapath keeps the configuration, the list head, the link memory
    // and the response registers.
    fbfla_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- sim/fixed_block_free_list_allocator_chk.sv -----
module fixed_block_free_list_allocator_chk (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [fbfla_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] block_index
    input  logic                          s_tuser,   // [0] mode
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [fbfla_pkg::TDATA_W-1:0] m_tdata,   // [7:0] granted_index, [27:8] granted_offset
    input  logic [1:0]                    m_tuser,   // [1:0] status
    output int                            error_count,
    output int                            pending_count,
    output int                            grant_count,
    output int                            empty_count,
    output int                            reject_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import fbfla_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   index;
        logic [OFFSET_W-1:0] offset;
    } reply_t;

    // Shadow copy of the pool: registers, list head and link memory.
    logic [BYTES_W-1:0] blk_bytes;
    logic [COUNT_W-1:0] blk_count;
    logic [LINK_W-1:0]  head;
    logic [LINK_W-1:0]  link [MAX_BLOCKS];
    reply_t             pending_replies [$];

    function automatic int pool_size();
        return (blk_count > COUNT_W'(MAX_BLOCKS)) ? MAX_BLOCKS : int'(blk_count);
    endfunction

    // Every register write lays the list out again as 0, 1, ..., count-1.
    function automatic void rebuild_list();
        int n;
        n = pool_size();
        for (int i = 0; i < MAX_BLOCKS; i++)
            link[i] = (i + 1 < n) ? LINK_W'(i + 1) : LIST_END;
        head = (n > 0) ? '0 : LIST_END;
    endfunction

    // Applies one request to the shadow pool and returns the reply it must produce.
    function automatic reply_t serve_request(logic mode, logic [ADDR_W-1:0] idx);
        reply_t      r;
        logic [31:0] product;
        r.status = STATUS_DONE;
        r.index  = '0;
        r.offset = '0;
        if (mode == MODE_ALLOC) begin
            if (head >= LIST_END) begin
                r.status = STATUS_EMPTY;
                empty_count++;
            end else begin
                r.index  = head[ADDR_W-1:0];
                product  = 32'(head) * 32'(blk_bytes);
                r.offset = product[OFFSET_W-1:0];
                head     = link[head[ADDR_W-1:0]];
                grant_count++;
            end
        end else if (int'(idx) >= pool_size()) begin
            r.status = STATUS_RANGE;
            reject_count++;
        end else begin
            // No double-free check: the block is simply pushed again.
            link[idx] = head;
            head      = {1'b0, idx};
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            blk_bytes = BYTES_RESET;
            blk_count = COUNT_RESET;
            rebuild_list();
            pending_replies.delete();
        end else begin
            // Compare before predicting, so a stray reply never meets a fresh request.
            if (m_tvalid && m_tready) begin
                if (pending_replies.size() == 0) begin
                    error_count++;
                    $display("%0t ns: reply with none outstanding, expected nothing, got %h/%h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = pending_replies.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tuser));
                    check_field("granted_index", 32'(want.index), 32'(m_tdata[7:0]));
                    check_field("granted_offset", 32'(want.offset),
                                32'(m_tdata[8 +: OFFSET_W]));
                    check_field("tdata padding", 32'd0,
                                32'(m_tdata[TDATA_W-1:8+OFFSET_W]));
                end
            end
            if (cfg_we) begin
                if (cfg_index == REG_BLOCK_BYTES)
                    blk_bytes = cfg_wdata[BYTES_W-1:0];
                else
                    blk_count = cfg_wdata[COUNT_W-1:0];
                rebuild_list();
            end
            if (s_tvalid && s_tready)
                pending_replies.push_back(serve_request(s_tuser, s_tdata));
        end
        pending_count = pending_replies.size();
    end

endmodule

// ----- sim/fixed_block_free_list_allocator_tb.sv -----
module fixed_block_free_list_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fbfla_pkg::*;

    // Run shape. Random phases each start from a fresh pool setting.
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 78;
    localparam int GAP_MAX       = 17;
    localparam int LONG_HOLD     = 80;
    localparam int DRAIN_CYCLES  = 8;
    // This limit leaves a wide margin over the slowest honest run.
    localparam int RUN_LIMIT_NS  = 3_000_000;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic               cfg_index;
    logic [CFG_W-1:0]   cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;   // [7:0] block_index
    logic               s_tuser;   // [0] mode
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;   // [7:0] granted_index, [27:8] granted_offset
    logic [1:0]         m_tuser;   // [1:0] status

    int error_count;
    int pending_count;
    int grant_count;
    int empty_count;
    int reject_count;

    // Stimulus-side bookkeeping. None of this predicts replies; it only steers
    // free requests toward blocks that are really out on loan.
    bit         sender_idles;
    bit         receiver_idles;
    bit         hold_req;
    int         pool_blocks;
    int         requests_sent;
    int         settings_used;
    logic [7:0] held_blocks [$];
    logic       in_flight_modes [$];

    fixed_block_free_list_allocator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    fixed_block_free_list_allocator_chk checker_inst (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (error_count),
        .pending_count (pending_count),
        .grant_count   (grant_count),
        .empty_count   (empty_count),
        .reject_count  (reject_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // Receiver. After each accepted reply it draws a random stall while receiver_idles is set.
    // When the stimulus raises hold_req, it instead refuses replies for a long stall,
    // so the block's output and holding registers fill and s_tready drops.
    initial begin : receiver
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                stall = receiver_idles ? $urandom_range(0, GAP_MAX) : 0;
            if (hold_req) begin
                stall    = LONG_HOLD;
                hold_req = 1'b0;
            end
            @(negedge aclk);
            m_tready <= aresetn && (stall == 0);
            if (stall > 0)
                stall--;
        end
    end

    // Tracks which kind of request each reply answers, so blocks that were
    // granted can later be handed back with a free request.
    always @(posedge aclk) begin
        logic resp_mode;
        if (aresetn) begin
            if (m_tvalid && m_tready && in_flight_modes.size() > 0) begin
                resp_mode = in_flight_modes.pop_front();
                if (resp_mode == MODE_ALLOC && m_tuser == STATUS_DONE)
                    held_blocks.push_back(m_tdata[7:0]);
            end
            if (s_tvalid && s_tready)
                in_flight_modes.push_back(s_tuser);
        end
    end

    // Offers one request and returns at the falling edge after it was taken.
    // A request that follows with no gap keeps s_tvalid high, so the valid is
    // never dropped and raised within one time step.
    task automatic send_request(logic mode, logic [7:0] idx);
        int gap;
        gap = sender_idles ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= idx;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        requests_sent++;
        @(negedge aclk);
    endtask

    // Stops offering requests until every outstanding reply has come back, then
    // lets the block settle before returning.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // Registers are only touched with the block idle. Any write rebuilds the
    // free list, so blocks held before it no longer mean anything.
    task automatic configure(bit set_bytes, logic [CFG_W-1:0] bytes_word,
                             bit set_count, logic [CFG_W-1:0] count_word);
        int cnt;
        wait_idle();
        if (set_bytes)
            write_reg(REG_BLOCK_BYTES, bytes_word);
        if (set_count) begin
            write_reg(REG_BLOCK_COUNT, count_word);
            cnt         = int'(count_word[COUNT_W-1:0]);
            pool_blocks = (cnt > MAX_BLOCKS) ? MAX_BLOCKS : cnt;
        end
        held_blocks.delete();
        settings_used++;
    endtask

    // Block sizes: mostly legal multiples of eight, sometimes the extremes, and
    // now and then an arbitrary 13-bit value (odd, zero, or large enough to wrap
    // the offset).
    function automatic logic [CFG_W-1:0] random_bytes();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return CFG_W'($urandom_range(1, 512) * 8);
        else if (pick < 80)
            return 13'd8;
        else if (pick < 90)
            return 13'd4096;
        return CFG_W'($urandom);
    endfunction

    // Block counts lean small so the pool runs dry often; zero, saturating
    // counts and junk in the unused upper bits are mixed in.
    function automatic logic [CFG_W-1:0] random_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return CFG_W'($urandom_range(1, 16));
        else if (pick < 75)
            return CFG_W'($urandom_range(17, 256));
        else if (pick < 83)
            return 13'd256;
        else if (pick < 88)
            return 13'd1;
        else if (pick < 93)
            return 13'd0;
        else if (pick < 97)
            return CFG_W'($urandom_range(257, 511));
        return {4'($urandom), 9'($urandom_range(1, 16))};
    endfunction

    // Most free requests return a block that is really held; the rest are
    // in-range frees that may repeat a free block, or any index at all.
    task automatic random_request(int alloc_pct);
        int         pick;
        int         k;
        logic [7:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct) begin
            send_request(MODE_ALLOC, 8'($urandom));
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 80 && held_blocks.size() > 0) begin
                k   = $urandom_range(0, held_blocks.size() - 1);
                idx = held_blocks[k];
                held_blocks.delete(k);
                send_request(MODE_FREE, idx);
            end else if (pick < 90 && pool_blocks > 0) begin
                send_request(MODE_FREE, 8'($urandom_range(0, pool_blocks - 1)));
            end else begin
                send_request(MODE_FREE, 8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        int alloc_pct;
        int which;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_BLOCK_BYTES;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = MODE_ALLOC;
        hold_req       = 1'b0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        pool_blocks    = MAX_BLOCKS;
        requests_sent  = 0;
        settings_used  = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset geometry: 16-byte blocks, 256 of them. The index field of an
        // allocate request is ignored, so it carries all ones and all zeros.
        send_request(MODE_ALLOC, 8'hFF);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_FREE, 8'd255);
        send_request(MODE_ALLOC, 8'h00);

        // Largest legal block, and the top block, give the largest offset.
        configure(1'b1, 13'd4096, 1'b1, 13'd256);
        send_request(MODE_FREE, 8'd255);
        send_request(MODE_ALLOC, 8'h00);

        // An odd size at the top of the register field makes the offset wrap.
        configure(1'b1, 13'h1FFF, 1'b0, '0);
        send_request(MODE_FREE, 8'd255);
        send_request(MODE_ALLOC, 8'h00);

        // Zero-byte blocks in a pool of three: drain it to empty, free an index
        // just past the end, then free the same block twice and take it back.
        configure(1'b1, 13'd0, 1'b1, 13'd3);
        repeat (4) send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_FREE, 8'd3);
        send_request(MODE_FREE, 8'd2);
        send_request(MODE_FREE, 8'd2);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_ALLOC, 8'h00);

        // A pool with no blocks: nothing to allocate and nothing is in range.
        configure(1'b0, '0, 1'b1, 13'd0);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_FREE, 8'd0);

        // A count above the pool size saturates to the full pool.
        configure(1'b1, 13'd8, 1'b1, 13'd300);
        send_request(MODE_FREE, 8'd255);
        send_request(MODE_ALLOC, 8'h00);

        // Bits above the count field are junk; only a one-block pool remains.
        configure(1'b0, '0, 1'b1, 13'h1E01);
        send_request(MODE_ALLOC, 8'h00);
        send_request(MODE_ALLOC, 8'h00);

        // Random phases. The mix of allocate and free requests shifts every
        // twenty requests, so the pool alternately drains and refills.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            which = $urandom_range(0, 4);
            configure(which != 0, random_bytes(), which != 1, random_count());
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            alloc_pct      = 50;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 20 == 0)
                    alloc_pct = 25 * $urandom_range(1, 3);
                if (p == 2 && i == 20) begin
                    // Back-to-back requests against a receiver that stops
                    // taking replies: the block must stall its input.
                    sender_idles = 1'b0;
                    hold_req     = 1'b1;
                end
                if (p == 2 && i == 40)
                    sender_idles = 1'b1;
                if (p == 4 && i == PHASE_ITEMS / 2)
                    wait_idle();
                random_request(alloc_pct);
            end
        end

        wait_idle();
        $display("Run covered %0d requests over %0d pool settings, with a long reply stall",
                 requests_sent, settings_used);
        $display("and a full drain: %0d grants, %0d empty-pool replies, %0d rejected frees.",
                 grant_count, empty_count, reject_count);
        if (error_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/fbfla_pkg.sv
rtl/core/fbfla_ram.sv
rtl/core/fbfla_ctrl.sv
rtl/core/fbfla_dp.sv
rtl/core/fixed_block_free_list_allocator.sv
sim/fixed_block_free_list_allocator_chk.sv
sim/fixed_block_free_list_allocator_tb.sv
